// ===== sv/nmea_rmc_position_parser_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef NMEA_RMC_POSITION_PARSER_UNIT_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NRMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrmc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define NRMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrmc assertion failed");

`endif

// ===== sv/nrmc_pkg.sv =====
`default_nettype none

package nrmc_pkg;

	// request classes handed from the front to the back
	typedef enum logic [2:0] {
		TOK_HDR_ERR  = 3'd0,
		TOK_HDR_DONE = 3'd1,
		TOK_COMMA    = 3'd2,
		TOK_STAR     = 3'd3,
		TOK_CHAR     = 3'd4
	} tok_op_t;

	typedef struct packed {
		tok_op_t    op;
		logic [7:0] ch;
	} token_t;

	localparam logic [2:0] HDR_LAST = 3'd6;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [3:0] FLD_STATUS = 4'd1;
	localparam logic [3:0] FLD_LAT    = 4'd2;
	localparam logic [3:0] FLD_NS     = 4'd3;
	localparam logic [3:0] FLD_LON    = 4'd4;
	localparam logic [3:0] FLD_EW     = 4'd5;
	localparam logic [3:0] FLD_MAX    = 4'd15;

	localparam logic [15:0] MAG_MAX = 16'hFFFF;

	// "$GPRMC,"
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h24;
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h50;
			3'd3:    c = 8'h52;
			3'd4:    c = 8'h4D;
			3'd5:    c = 8'h43;
			3'd6:    c = 8'h2C;
			default: c = 8'h24;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/nrmc_front.sv =====
`default_nettype none

module nrmc_front import nrmc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            push_valid,
	input  wire logic       push_ready,
	output token_t          push_data
);

	logic       in_body_q;
	logic [2:0] hdr_pos_q;
	logic       accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		push_valid     = 1'b0;
		push_data.op   = TOK_CHAR;
		push_data.ch   = rx_byte;
		if (in_valid) begin
			if (!in_body_q) begin
				if (rx_byte != hdr_char(hdr_pos_q)) begin
					push_valid   = 1'b1;
					push_data.op = TOK_HDR_ERR;
				end else if (hdr_pos_q == HDR_LAST) begin
					push_valid   = 1'b1;
					push_data.op = TOK_HDR_DONE;
				end
			end else begin
				push_valid = 1'b1;
				if (rx_byte == CH_COMMA) begin
					push_data.op = TOK_COMMA;
				end else if (rx_byte == CH_STAR) begin
					push_data.op = TOK_STAR;
				end
			end
		end
	end

	// header hunt and body tracking depend on the byte stream alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			hdr_pos_q <= '0;
		end else if (accept) begin
			if (!in_body_q) begin
				if (rx_byte != hdr_char(hdr_pos_q)) begin
					hdr_pos_q <= '0;
				end else if (hdr_pos_q == HDR_LAST) begin
					hdr_pos_q <= '0;
					in_body_q <= 1'b1;
				end else begin
					hdr_pos_q <= hdr_pos_q + 3'd1;
				end
			end else if (rx_byte == CH_STAR) begin
				in_body_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/nrmc_queue.sv =====
`default_nettype none

module nrmc_queue import nrmc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire token_t push_data,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output token_t      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/nrmc_back.sv =====
`default_nettype none

module nrmc_back import nrmc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire token_t        pop_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               kind,
	output logic               fix_valid,
	output logic signed [16:0] latitude,
	output logic signed [16:0] longitude
);

	logic [3:0]         fnum_q,    fnum_d;
	logic [1:0]         flen_q,    flen_d;
	logic [7:0]         first_q,   first_d;
	logic [15:0]        acc_q,     acc_d;
	logic               ended_q,   ended_d;
	logic               neg_q,     neg_d;
	logic               started_q, started_d;
	logic               status_q,  status_d;
	logic signed [16:0] plat_q,    plat_d;
	logic signed [16:0] plon_q,    plon_d;
	logic               north_q,   north_d;
	logic               east_q,    east_d;
	logic signed [16:0] hlat_q,    hlat_d;
	logic signed [16:0] hlon_q,    hlon_d;

	logic               out_valid_q;
	logic               kind_q;
	logic               fix_q;
	logic signed [16:0] lat_q;
	logic signed [16:0] lon_q;

	logic               emit;
	logic               emit_kind;
	logic               do_pop;
	logic [7:0]         c;
	logic               is_digit;
	logic               is_space;
	logic signed [16:0] mag;
	logic signed [16:0] v;
	logic [19:0]        n;

	assign c        = pop_data.ch;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign mag      = $signed({1'b0, acc_q});
	assign v        = neg_q ? 17'(-mag) : mag;
	assign n        = 20'({acc_q, 3'b000}) + 20'({acc_q, 1'b0}) + 20'(c[3:0]);

	assign emit      = (pop_data.op == TOK_HDR_ERR) || (pop_data.op == TOK_STAR);
	// requests that produce no result never wait on the output register
	assign pop_ready = !emit || !out_valid_q || out_ready;
	assign do_pop    = pop_valid && pop_ready;

	always_comb begin
		fnum_d    = fnum_q;
		flen_d    = flen_q;
		first_d   = first_q;
		acc_d     = acc_q;
		ended_d   = ended_q;
		neg_d     = neg_q;
		started_d = started_q;
		status_d  = status_q;
		plat_d    = plat_q;
		plon_d    = plon_q;
		north_d   = north_q;
		east_d    = east_q;
		hlat_d    = hlat_q;
		hlon_d    = hlon_q;
		emit_kind = 1'b0;

		unique case (pop_data.op) inside
			TOK_HDR_ERR: begin
				emit_kind = 1'b0;
			end
			TOK_HDR_DONE: begin
				fnum_d    = '0;
				flen_d    = '0;
				first_d   = '0;
				acc_d     = '0;
				ended_d   = 1'b0;
				neg_d     = 1'b0;
				started_d = 1'b0;
				status_d  = 1'b0;
				plat_d    = '0;
				plon_d    = '0;
				north_d   = 1'b0;
				east_d    = 1'b0;
			end
			TOK_COMMA, TOK_STAR: begin
				case (fnum_q)
					FLD_STATUS: status_d = (flen_q == 2'd1) && (first_q == CH_A);
					FLD_LAT:    plat_d   = v;
					FLD_NS:     north_d  = (flen_q == 2'd1) && (first_q == CH_N);
					FLD_LON:    plon_d   = v;
					FLD_EW:     east_d   = (flen_q == 2'd1) && (first_q == CH_E);
					default:    ;
				endcase
				if (fnum_q != FLD_MAX) begin
					fnum_d = fnum_q + 4'd1;
				end
				flen_d    = '0;
				first_d   = '0;
				acc_d     = '0;
				ended_d   = 1'b0;
				neg_d     = 1'b0;
				started_d = 1'b0;
				if (pop_data.op == TOK_STAR) begin
					emit_kind = 1'b1;
					if (status_d) begin
						hlat_d = north_d ? plat_d : 17'(-plat_d);
						hlon_d = east_d ? plon_d : 17'(-plon_d);
					end
				end
			end
			TOK_CHAR: begin
				if (flen_q == 2'd0) begin
					first_d = c;
				end
				if (flen_q != 2'd3) begin
					flen_d = flen_q + 2'd1;
				end
				if (!ended_q) begin
					if (!started_q && is_space) begin
						// leading white space is skipped
					end else if (!started_q && ((c == CH_MINUS) || (c == CH_PLUS))) begin
						started_d = 1'b1;
						neg_d     = (c == CH_MINUS);
					end else begin
						started_d = 1'b1;
						if (is_digit) begin
							acc_d = (n > 20'(MAG_MAX)) ? MAG_MAX : n[15:0];
						end else begin
							ended_d = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnum_q    <= '0;
			flen_q    <= '0;
			first_q   <= '0;
			acc_q     <= '0;
			ended_q   <= 1'b0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			status_q  <= 1'b0;
			plat_q    <= '0;
			plon_q    <= '0;
			north_q   <= 1'b0;
			east_q    <= 1'b0;
			hlat_q    <= '0;
			hlon_q    <= '0;
		end else if (do_pop) begin
			fnum_q    <= fnum_d;
			flen_q    <= flen_d;
			first_q   <= first_d;
			acc_q     <= acc_d;
			ended_q   <= ended_d;
			neg_q     <= neg_d;
			started_q <= started_d;
			status_q  <= status_d;
			plat_q    <= plat_d;
			plon_q    <= plon_d;
			north_q   <= north_d;
			east_q    <= east_d;
			hlat_q    <= hlat_d;
			hlon_q    <= hlon_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && emit) begin
			kind_q <= emit_kind;
			fix_q  <= emit_kind && status_d;
			lat_q  <= hlat_d;
			lon_q  <= hlon_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign fix_valid = fix_q;
	assign latitude  = lat_q;
	assign longitude = lon_q;

endmodule

`default_nettype wire

// ===== sv/nmea_rmc_position_parser_unit.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   rx_byte[7:0]
// out      out_valid / out_ready kind, fix_valid, latitude[16:0], longitude[16:0]
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through the request queue, then the output register in the back end.
// arst_n clears the header hunt, the field state and the held position to zero.
// A stalled output holds only requests that make a result; others keep draining.
// in_ready drops only when the QUEUE_DEPTH-entry request queue is full.
`default_nettype none

module nmea_rmc_position_parser_unit import nrmc_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               kind,
	output logic               fix_valid,
	output logic signed [16:0] latitude,
	output logic signed [16:0] longitude
);

	logic   push_valid;
	logic   push_ready;
	token_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	token_t pop_data;

	nrmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	nrmc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	nrmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.fix_valid (fix_valid),
		.latitude  (latitude),
		.longitude (longitude)
	);

endmodule

`default_nettype wire

// ===== sv/nrmc_checker.sv =====
`default_nettype none
`include "nmea_rmc_position_parser_unit_macros.svh"

module nrmc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [7:0]        rx_byte,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              kind,
	input wire logic              fix_valid,
	input wire logic signed [16:0] latitude,
	input wire logic signed [16:0] longitude
);

	logic signed [16:0] last_lat_q;
	logic signed [16:0] last_lon_q;
	logic               in_seen;

	assign in_seen = in_valid && in_ready && (rx_byte == rx_byte);

	// position as last delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_lat_q <= '0;
			last_lon_q <= '0;
		end else if (out_valid && out_ready) begin
			last_lat_q <= latitude;
			last_lon_q <= longitude;
		end
	end

	`NRMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(latitude) && $stable(longitude) && $stable(kind) && $stable(fix_valid))
	`NRMC_ASSERT_NOW(a_err_no_fix, out_valid && !kind, !fix_valid)
	`NRMC_ASSERT_NOW(a_pos_held, out_valid && !(kind && fix_valid), (latitude == last_lat_q) && (longitude == last_lon_q))
	`NRMC_ASSERT_NOW(a_no_min, out_valid || in_seen, (latitude != 17'sh10000) || !out_valid)
	`NRMC_ASSERT_NOW(a_lon_no_min, out_valid, longitude != 17'sh10000)

endmodule

bind nmea_rmc_position_parser_unit nrmc_checker u_nrmc_checker (.*);

`default_nettype wire
